// ----- hw/rtl/itda_pkg.sv -----
// Package for the integer to decimal ASCII core: sizes, character codes and
// the record that travels down the conversion pipeline. No dependencies.
`timescale 1ns / 1ps

package itda_pkg;

    localparam int WIDTH = 32;
    localparam int NDIG = ((WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BCD_W = NDIG * 4;
    localparam int STEPS = 8;
    localparam int NSTAGE = (WIDTH + STEPS - 1) / STEPS;
    localparam int PAD_W = NSTAGE * STEPS;
    localparam int IDX_W = $clog2(NDIG);

    localparam logic [7:0] MINUS_CODE = 8'd45;
    localparam logic [7:0] ZERO_CODE = 8'd48;
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
        logic [PAD_W-1:0] bin;
    } stage_data_t;

endpackage

// ----- hw/rtl/itda_sign_stage.sv -----
// First pipeline stage: registers the sign and the unsigned magnitude.
// Depends on itda_pkg.
`timescale 1ns / 1ps

module itda_sign_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [itda_pkg::WIDTH-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output itda_pkg::stage_data_t               out_data
);
    import itda_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    stage_data_t       data_reg;
    stage_data_t       data_next;
    logic [WIDTH-1:0]  raw;
    logic [WIDTH-1:0]  mag;
    logic              load;

    assign in_stall = valid_reg && out_stall;
    assign load = in_valid && !in_stall;
    assign raw = value;
    assign mag = raw[WIDTH-1] ? WIDTH'(~raw + WIDTH'(1)) : raw;

    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
        end
        data_next.neg = raw[WIDTH-1];
        data_next.bcd = '0;
        data_next.bin = PAD_W'(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

// ----- hw/rtl/itda_dabble_stage.sv -----
// One double-dabble pipeline stage: shifts STEPS magnitude bits into the
// BCD digits with add-3 correction. Depends on itda_pkg.
`timescale 1ns / 1ps

module itda_dabble_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  itda_pkg::stage_data_t in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output itda_pkg::stage_data_t out_data
);
    import itda_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    stage_data_t data_reg;
    stage_data_t data_next;
    logic        load;

    assign in_stall = valid_reg && out_stall;
    assign load = in_valid && !in_stall;

    always_comb
    begin
        logic [BCD_W-1:0] b;
        logic [PAD_W-1:0] s;
        b = in_data.bcd;
        s = in_data.bin;
        for (int k = 0; k < STEPS; k++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (b[d*4 +: 4] >= BCD_ADJ_MIN)
                begin
                    b[d*4 +: 4] = b[d*4 +: 4] + BCD_ADJ_ADD;
                end
            end
            {b, s} = {b, s} << 1;
        end
        data_next.neg = in_data.neg;
        data_next.bcd = b;
        data_next.bin = s;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

// ----- hw/rtl/itda_serializer.sv -----
// Character emitter: holds one converted number and sends its sign and
// significant digits, one per transfer, through an output register.
// Depends on itda_pkg.
`timescale 1ns / 1ps

module itda_serializer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  itda_pkg::stage_data_t in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            char_code,
    output logic                  last_char
);
    import itda_pkg::*;

    logic             job_reg;
    logic             job_next;
    logic             minus_reg;
    logic             minus_next;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       char_reg;
    logic [7:0]       char_next;
    logic             last_reg;
    logic             last_next;

    logic             out_free;
    logic             emit;
    logic             emit_last;
    logic             load;
    logic [IDX_W-1:0] lead_idx;
    logic [3:0]       cur_digit;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit = job_reg && out_free;
    assign emit_last = emit && !minus_reg && (idx_reg == '0);
    assign in_stall = job_reg && !emit_last;
    assign load = in_valid && !in_stall;
    assign cur_digit = bcd_reg[{idx_reg, 2'b00} +: 4];

    always_comb
    begin
        lead_idx = '0;
        for (int d = 0; d < NDIG; d++)
        begin
            if (in_data.bcd[d*4 +: 4] != 4'd0)
            begin
                lead_idx = IDX_W'(d);
            end
        end
    end

    always_comb
    begin
        job_next = job_reg;
        minus_next = minus_reg;
        bcd_next = bcd_reg;
        idx_next = idx_reg;
        out_valid_next = out_valid_reg;
        char_next = char_reg;
        last_next = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (minus_reg)
            begin
                char_next = MINUS_CODE;
                last_next = 1'b0;
                minus_next = 1'b0;
            end
            else
            begin
                char_next = ZERO_CODE + {4'd0, cur_digit};
                last_next = (idx_reg == '0);
                idx_next = idx_reg - IDX_W'(1);
            end
            if (emit_last)
            begin
                job_next = 1'b0;
            end
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            job_next = 1'b1;
            minus_next = in_data.neg;
            bcd_next = in_data.bcd;
            idx_next = lead_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_reg <= job_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        minus_reg <= minus_next;
        bcd_reg <= bcd_next;
        idx_reg <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

endmodule

// ----- hw/rtl/int_to_decimal_ascii_core.sv -----
// Converts a signed WIDTH-bit integer to its decimal ASCII text, most
// significant character first, with a leading '-' for negative values and
// last_char marking the final digit. A number enters a sign stage, then
// NSTAGE double-dabble stages (4 at WIDTH 32), then the character emitter,
// whose output register holds each character. Numbers may enter every
// cycle while the pipeline has room; the sustained rate is set by the
// one-character output port: a number of n characters (1 to 11 at
// WIDTH 32) takes n transfers there, and the next number's characters
// follow with no gap. Nothing is kept between numbers. Depends on
// itda_pkg, itda_sign_stage, itda_dabble_stage and itda_serializer.
`timescale 1ns / 1ps

module int_to_decimal_ascii_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [itda_pkg::WIDTH-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        char_code,
    output logic                              last_char
);
    import itda_pkg::*;

    logic        st_valid [NSTAGE+1];
    logic        st_stall [NSTAGE+1];
    stage_data_t st_data  [NSTAGE+1];

    itda_sign_stage u_sign (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (st_valid[0]),
        .out_stall (st_stall[0]),
        .out_data  (st_data[0])
    );

    for (genvar i = 0; i < NSTAGE; i++)
    begin : g_dabble
        itda_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[i]),
            .in_stall  (st_stall[i]),
            .in_data   (st_data[i]),
            .out_valid (st_valid[i+1]),
            .out_stall (st_stall[i+1]),
            .out_data  (st_data[i+1])
        );
    end

    itda_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid[NSTAGE]),
        .in_stall  (st_stall[NSTAGE]),
        .in_data   (st_data[NSTAGE]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

endmodule
